>>> hdl/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// Shared constants and controller/datapath interface types for the
// addressed frame receiver.
// ----------------------------------------------------------------------------
package afr_pkg;

  localparam int BUFFER_BYTES   = 8;
  localparam int FRAME_BYTES    = 6;
  localparam int CHECK_POSITION = 4;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] ADDR_RESET   = 8'h01;

  localparam int IDX_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

  // check byte past the end of the store reads as zero
  localparam bit               CHECK_IN  = (CHECK_POSITION < BUFFER_BYTES);
  localparam logic [IDX_W-1:0] CHECK_IDX = CHECK_IN ? IDX_W'(CHECK_POSITION) : '0;
  localparam logic [IDX_W-1:0] EMIT_END  = IDX_W'(FRAME_BYTES - 1);

  typedef struct packed {
    logic load;       // store the accepted byte
    logic clear;      // empty the frame store
    logic emit_next;  // advance to the next frame byte
    logic err_sel;    // present the checksum error result
  } afr_cmd_t;

  typedef struct packed {
    logic addr_bad;    // first stored byte is not the node address
    logic frame_done;  // newline without overrun closed a full-length frame
    logic csum_ok;     // running parity matches the check byte
    logic full;        // store holds BUFFER_BYTES bytes
    logic emit_last;   // emit pointer sits on the final frame byte
  } afr_stat_t;

endpackage

>>> hdl/afr_datapath.sv
// ----------------------------------------------------------------------------
// afr_datapath
// Frame store, fill count, running parity, node address register and the
// result field selection.
// ----------------------------------------------------------------------------
module afr_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             overrun_i,
  input  afr_pkg::afr_cmd_t  cmd_i,
  output afr_pkg::afr_stat_t stat_o,
  output logic             kind_o,
  output logic [7:0]       frame_byte_o,
  output logic             last_o
);
  import afr_pkg::*;

  logic [7:0]       store_q [BUFFER_BYTES];
  logic [CNT_W-1:0] fill_q;
  logic [7:0]       parity_q;
  logic [7:0]       node_addr_q;
  logic             nl_q;
  logic [IDX_W-1:0] emit_idx_q;
  logic             full_now;
  logic             do_clear;
  logic [7:0]       check_byte;

  assign full_now = (int'(fill_q) >= BUFFER_BYTES);
  // a byte arriving at a full store is dropped and the store emptied
  assign do_clear = cmd_i.clear || (cmd_i.load && full_now);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUFFER_BYTES; i++) begin
        store_q[i] <= '0;
      end
      fill_q   <= '0;
      parity_q <= '0;
    end else if (do_clear) begin
      for (int i = 0; i < BUFFER_BYTES; i++) begin
        store_q[i] <= '0;
      end
      fill_q   <= '0;
      parity_q <= '0;
    end else if (cmd_i.load) begin
      store_q[fill_q[IDX_W-1:0]] <= rx_byte_i;
      fill_q <= fill_q + CNT_W'(1);
      if (int'(fill_q) < CHECK_POSITION) begin
        parity_q <= parity_q ^ rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q <= ADDR_RESET;
    end else if (cfg_we_i) begin
      node_addr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_q       <= 1'b0;
      emit_idx_q <= '0;
    end else begin
      if (cmd_i.load) begin
        nl_q <= (rx_byte_i == NEWLINE_BYTE) && !overrun_i;
      end
      if (cmd_i.clear) begin
        emit_idx_q <= '0;
      end else if (cmd_i.emit_next) begin
        emit_idx_q <= emit_idx_q + IDX_W'(1);
      end
    end
  end

  assign check_byte = CHECK_IN ? store_q[CHECK_IDX] : 8'h00;

  assign stat_o.addr_bad   = (store_q[0] != node_addr_q);
  assign stat_o.frame_done = nl_q && (int'(fill_q) == FRAME_BYTES);
  assign stat_o.csum_ok    = (parity_q == check_byte);
  assign stat_o.full       = full_now;
  assign stat_o.emit_last  = (emit_idx_q == EMIT_END);

  assign kind_o       = cmd_i.err_sel;
  assign frame_byte_o = cmd_i.err_sel ? 8'h00 : store_q[emit_idx_q];
  assign last_o       = cmd_i.err_sel || stat_o.emit_last;

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (fill_q == '0) && (parity_q == 8'h00))
    else $error("store not empty after clear");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= BUFFER_BYTES)
    else $error("fill count beyond store depth");

endmodule

>>> hdl/afr_ctrl.sv
// ----------------------------------------------------------------------------
// afr_ctrl
// Sequencer: takes one byte, judges it, then drains an accepted frame or
// reports a checksum error.
// ----------------------------------------------------------------------------
module afr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  afr_pkg::afr_stat_t stat_i,
  output afr_pkg::afr_cmd_t  cmd_o
);
  import afr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_EMIT = 4'b0100,
    S_ERR  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   in_acc;
  logic   out_acc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_EMIT) || (state_q == S_ERR);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  always_comb begin
    state_d         = state_q;
    cmd_o.load      = 1'b0;
    cmd_o.clear     = 1'b0;
    cmd_o.emit_next = 1'b0;
    cmd_o.err_sel   = (state_q == S_ERR);
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.addr_bad) begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end else if (stat_i.frame_done) begin
          state_d = stat_i.csum_ok ? S_EMIT : S_ERR;
        end else begin
          cmd_o.clear = stat_i.full;
          state_d     = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          if (stat_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
          end
        end
      end
      S_ERR: begin
        if (out_acc) begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        cmd_o.clear = 1'b1;
        state_d     = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_not_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !cmd_o.clear)
    else $error("load and clear together");

  a_accept_evaluates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_EVAL) && !out_valid_o)
    else $error("byte not evaluated after transaction");

  a_final_result_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (state_q == S_ERR || stat_i.emit_last) |=> !out_valid_o && !in_stall_o)
    else $error("results continue past the final one");

endmodule

>>> hdl/addressed_frame_receiver.sv
// ----------------------------------------------------------------------------
// addressed_frame_receiver
// Collects serial bytes into a frame store, checks node address and XOR
// checksum, and replays accepted frames byte by byte.
// ----------------------------------------------------------------------------
// Each received byte is first stored, and the controller then judges the
// updated store (address, length, checksum). When a byte completes a valid
// frame the block then drains FRAME_BYTES results at one per cycle while
// the output is not stalled, or one error result on a checksum mismatch,
// and takes no new byte until the last result transaction; a stalled output
// holds the block in that drain. The frame store is a small register file
// read at the drain pointer, so draining is paced by that single read port.
module addressed_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       overrun_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] frame_byte_o,
  output logic       last_o
);
  import afr_pkg::*;

  afr_cmd_t  cmd;
  afr_stat_t stat;

  afr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  afr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_byte_i    (rx_byte_i),
    .overrun_i    (overrun_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_o       (kind_o),
    .frame_byte_o (frame_byte_o),
    .last_o       (last_o)
  );

endmodule

>>> test/addressed_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// addressed_frame_receiver_tb
// Feeds serial bytes into the frame receiver and keeps its own copy of the
// frame store. From that copy it predicts every emitted frame byte and every
// checksum error, and compares each output transaction with the oldest
// prediction. Each phase runs under a different node address. Input gaps and
// output stalls are random, and one phase runs with no idling at all.
// ----------------------------------------------------------------------------
module addressed_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import afr_pkg::*;

  localparam int  CLK_PERIOD       = 12;
  localparam int  RESET_CYCLES     = 7;
  localparam int  CYCLE_LIMIT      = 400000;
  localparam int  SETTLE_CYCLES    = 8;
  localparam int  ITEMS_PER_PHASE  = 46;
  localparam int  MAX_SHOWN        = 10;
  localparam int  DIRECTED_COUNT   = 27;
  localparam logic KIND_FRAME      = 1'b0;
  localparam logic KIND_CSUM_ERR   = 1'b1;

  typedef enum int {FLAW_NONE, FLAW_CSUM, FLAW_OVERRUN, FLAW_ADDR, FLAW_SHORT, FLAW_LONG} flaw_e;

  typedef struct packed {
    logic [7:0] data;
    logic       ovr;
  } rx_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } frame_result_t;

  localparam logic [7:0] DIR_BYTES [DIRECTED_COUNT] = '{
    ADDR_RESET, 8'h00, 8'hFF, 8'h00, 8'hFE, NEWLINE_BYTE,
    ADDR_RESET, 8'hFF, 8'hFF, 8'hFF, 8'hFE, NEWLINE_BYTE,
    ADDR_RESET, 8'h12, 8'h34, 8'h56, 8'h00, NEWLINE_BYTE,
    8'h02,
    ADDR_RESET, 8'h11, 8'h22, 8'h33, 8'h01, NEWLINE_BYTE,
    NEWLINE_BYTE, 8'h00
  };
  localparam bit DIR_OVR [DIRECTED_COUNT] = '{
    0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0,
    1,
    0, 0, 0, 0, 0, 1,
    0, 0
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       overrun_i   = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       kind_o;
  logic [7:0] frame_byte_o;
  logic       last_o;

  rx_item_t      rx_queue[$];
  frame_result_t frame_out_q[$];

  // shadow of the receiver state
  logic [7:0] shadow_store [BUFFER_BYTES];
  int         shadow_fill;
  logic [7:0] shadow_parity;
  logic [7:0] shadow_addr;

  bit  calm;
  int  gap_left;
  int  stall_left;
  int  fail_count;
  int  cycles;

  addressed_frame_receiver uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .overrun_i   (overrun_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .frame_byte_o(frame_byte_o),
    .last_o      (last_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  task automatic flag_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("%s", what);
  endtask

  task automatic clear_shadow();
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    shadow_fill   = 0;
    shadow_parity = 8'h00;
  endtask

  // one received byte through the shadow store, predicted results queued
  task automatic absorb_byte(input rx_item_t item);
    logic [7:0] check_byte;
    if (shadow_fill >= BUFFER_BYTES) begin
      clear_shadow();
      return;
    end
    shadow_store[shadow_fill] = item.data;
    if (shadow_fill < CHECK_POSITION) shadow_parity ^= item.data;
    shadow_fill++;
    if (shadow_store[0] != shadow_addr) begin
      clear_shadow();
      return;
    end
    if (!item.ovr && item.data == NEWLINE_BYTE && shadow_fill == FRAME_BYTES) begin
      check_byte = (CHECK_POSITION < BUFFER_BYTES) ? shadow_store[CHECK_POSITION] : 8'h00;
      if (shadow_parity == check_byte) begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
          frame_out_q.push_back('{kind: KIND_FRAME, data: shadow_store[i],
                                  last: (i == FRAME_BYTES - 1)});
        end
      end else begin
        frame_out_q.push_back('{kind: KIND_CSUM_ERR, data: 8'h00, last: 1'b1});
      end
      clear_shadow();
      return;
    end
    if (shadow_fill >= BUFFER_BYTES) clear_shadow();
  endtask

  task automatic push_byte(input logic [7:0] data, input logic ovr);
    rx_queue.push_back('{data: data, ovr: ovr});
  endtask

  // a frame for the given address, optionally damaged; returns bytes queued
  task automatic push_frame(input logic [7:0] addr, input flaw_e flaw, output int count);
    logic [7:0] burst[$];
    logic [7:0] parity;
    int         ov_pos;
    int         target;
    burst  = {};
    parity = 8'h00;
    ov_pos = -1;
    burst.push_back(addr);
    for (int i = 1; i < FRAME_BYTES - 1; i++) burst.push_back(8'($urandom));
    for (int i = 0; i < CHECK_POSITION; i++) parity ^= burst[i];
    burst[CHECK_POSITION] = parity;
    burst.push_back(NEWLINE_BYTE);
    case (flaw)
      FLAW_CSUM: burst[CHECK_POSITION] ^= 8'($urandom_range(1, 255));
      FLAW_ADDR: burst[0] ^= 8'($urandom_range(1, 255));
      FLAW_OVERRUN: begin
        // mostly on the closing newline, where it matters most
        ov_pos = $urandom_range(0, 1) ? FRAME_BYTES - 1 : $urandom_range(0, FRAME_BYTES - 1);
      end
      FLAW_SHORT: begin
        target = $urandom_range(2, FRAME_BYTES - 1);
        while (burst.size() > target) burst.delete(1);
      end
      FLAW_LONG: begin
        target = $urandom_range(FRAME_BYTES + 1, BUFFER_BYTES + 1);
        while (burst.size() < target) burst.insert(1, 8'($urandom));
      end
      default: ;
    endcase
    foreach (burst[i]) push_byte(burst[i], i == ov_pos);
    count = burst.size();
  endtask

  task automatic wait_quiet();
    while (rx_queue.size() != 0 || in_valid_i || frame_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    shadow_addr = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input logic [7:0] addr);
    int pushed;
    int n;
    int pick;
    pushed = 0;
    while (pushed < ITEMS_PER_PHASE) begin
      pick = $urandom_range(0, 99);
      if (pick < 58)      push_frame(addr, FLAW_NONE, n);
      else if (pick < 68) push_frame(addr, FLAW_CSUM, n);
      else if (pick < 76) push_frame(addr, FLAW_OVERRUN, n);
      else if (pick < 82) push_frame(addr, FLAW_ADDR, n);
      else if (pick < 88) push_frame(addr, FLAW_SHORT, n);
      else if (pick < 93) push_frame(addr, FLAW_LONG, n);
      else begin
        n = $urandom_range(1, 4);
        repeat (n) push_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
      pushed += n;
    end
  endtask

  initial begin
    logic [7:0] phase_addr [5];
    phase_addr = '{ADDR_RESET, 8'h00, 8'hFF, NEWLINE_BYTE, 8'($urandom)};
    clear_shadow();
    shadow_addr = ADDR_RESET;
    calm        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIRECTED_COUNT; i++) push_byte(DIR_BYTES[i], DIR_OVR[i]);
    random_phase(ADDR_RESET);
    wait_quiet();

    for (int p = 1; p < 5; p++) begin
      calm = (p == 2);
      write_address(phase_addr[p]);
      random_phase(phase_addr[p]);
      wait_quiet();
    end

    if (fail_count == 0) begin
      $display("[addressed_frame_receiver] OK");
    end else begin
      $display("[addressed_frame_receiver] ERROR");
    end
    $finish;
  end

  // byte driver: predicts on each accepted transaction, then presents the next
  always @(posedge clk_i) begin
    int pick;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) absorb_byte('{data: rx_byte_i, ovr: overrun_i});
      if (in_valid_i && in_stall_o) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (rx_queue.size() != 0) begin
        rx_item_t item;
        item = rx_queue.pop_front();
        rx_byte_i  <= item.data;
        overrun_i  <= item.ovr;
        in_valid_i <= 1'b1;
        pick = $urandom_range(0, 99);
        if (calm || pick < 55) gap_left = 0;
        else if (pick < 90)    gap_left = $urandom_range(1, 3);
        else                   gap_left = $urandom_range(5, 30);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk_i) begin
    frame_result_t want;
    int            pick;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (frame_out_q.size() == 0) begin
          flag_failure($sformatf("unexpected result: kind=%0d byte=%02h last=%0d",
                                 kind_o, frame_byte_o, last_o));
        end else begin
          want = frame_out_q.pop_front();
          if (kind_o !== want.kind || frame_byte_o !== want.data || last_o !== want.last) begin
            flag_failure($sformatf({"result mismatch: expected kind=%0d byte=%02h last=%0d,",
                                    " got kind=%0d byte=%02h last=%0d"},
                                   want.kind, want.data, want.last,
                                   kind_o, frame_byte_o, last_o));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          out_stall_i <= 1'b0;
        end else if (pick < 93) begin
          stall_left = $urandom_range(0, 2);
          out_stall_i <= 1'b1;
        end else begin
          stall_left = $urandom_range(5, 30);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, frame_out_q.size());
      $display("[addressed_frame_receiver] ERROR");
      $finish;
    end
  end

endmodule
